@@ design/sdll_pkg.sv @@
package sdll_pkg;

  // default sizing
  localparam int SLOTS_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 32;
  localparam int VALUE_BITS_MAX = 64;

  // field widths
  localparam int FUNC_W = 3;
  localparam int NUM_W  = 10;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  // bus widths, whole bytes
  localparam int IN_W  = 48;
  localparam int OUT_W = 64;

  // fixed slots
  localparam int HEAD_SLOT  = 0;
  localparam int TAIL_SLOT  = 1;
  localparam int FIRST_SLOT = 2;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_RIGHT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_INS_LEFT   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DELETE     = 3'd4;
  localparam logic [FUNC_W-1:0] FN_QUERY      = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_LIVE = 2'd2;

  typedef struct packed {
    logic accept;
    logic eval;
    logic link;
    logic load_out;
  } sdll_cmd_t;

  typedef struct packed {
    logic need_link;
  } sdll_stat_t;

endpackage

@@ design/static_doubly_linked_list.sv @@
// Sequence: input transfer, EVAL, then RESP loads the result for query, delete, refused
// inserts and unused codes; a successful insert adds LINK between EVAL and RESP to patch the links.
// Throughput: one operation in flight, input closed until RESP has loaded the result; set by
// the registered memory read and up to two rounds of link writes; a held result adds stalls.
// Reset (rst, synchronous, active high): empty list, allocator at slot 2, no result pending;
// memories are not cleared, liveness is derived from the allocator and a deleted flag.
module static_doubly_linked_list #(
  parameter int SLOTS      = sdll_pkg::SLOTS_DEF,
  parameter int VALUE_BITS = sdll_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // operation stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // [2:0] func, [12:3] position, [44:13] value, [47:45] zero
  input  logic [sdll_pkg::IN_W-1:0]  s_tdata,
  // result stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [1:0] status, [11:2] node_number, [43:12] node_value,
  // [53:44] left_number, [63:54] right_number
  output logic [sdll_pkg::OUT_W-1:0] m_tdata
);

  // Controller sequences accept -> evaluate -> (link) -> respond; the
  // datapath owns the node memories, the end pointers and the allocator.
  sdll_pkg::sdll_cmd_t  cmd;
  sdll_pkg::sdll_stat_t stat;

  sdll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  sdll_dpath #(
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata)
  );

`ifndef SYNTHESIS
  // one operation at a time: input closes right after a transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an operation is in progress");

  // no result may appear in the cycle after an input transfer
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !$rose(m_tvalid))
    else $error("result offered before evaluation");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == sdll_pkg::ST_OK || m_tdata[1:0] == sdll_pkg::ST_FULL
                  || m_tdata[1:0] == sdll_pkg::ST_NOT_LIVE))
    else $error("undefined status code");

  // a failed operation reports nothing but its status
  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != sdll_pkg::ST_OK) |-> (m_tdata[63:2] == '0))
    else $error("nonzero fields on an error result");
`endif

endmodule

@@ design/sdll_ctrl.sv @@
module sdll_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output sdll_pkg::sdll_cmd_t cmd,
  input  sdll_pkg::sdll_stat_t stat
);

  typedef enum logic [1:0] {
    IDLE,
    EVAL,
    LINK,
    RESP
  } state_t;

  state_t state;

  // closed while reset is held
  assign s_tready     = (state == IDLE) && !rst;
  assign cmd.accept   = s_tready && s_tvalid;
  assign cmd.eval     = (state == EVAL);
  assign cmd.link     = (state == LINK);
  assign cmd.load_out = (state == RESP) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            state <= EVAL;
          end
        end
        EVAL: begin
          state <= stat.need_link ? LINK : RESP;
        end
        LINK: begin
          state <= RESP;
        end
        RESP: begin
          if (!m_tvalid || m_tready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase

      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ design/sdll_dpath.sv @@
module sdll_dpath #(
  parameter int SLOTS      = sdll_pkg::SLOTS_DEF,
  parameter int VALUE_BITS = sdll_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sdll_pkg::sdll_cmd_t           cmd,
  output sdll_pkg::sdll_stat_t          stat,
  input  logic [sdll_pkg::IN_W-1:0]     s_tdata,
  output logic [sdll_pkg::OUT_W-1:0]    m_tdata
);

  localparam int SW     = $clog2(SLOTS);
  localparam int NUM_W  = sdll_pkg::NUM_W;
  localparam int FUNC_W = sdll_pkg::FUNC_W;
  localparam int VAL_W  = sdll_pkg::VAL_W;
  localparam int STAT_W = sdll_pkg::STAT_W;
  localparam int VMAX   = sdll_pkg::VALUE_BITS_MAX;

  typedef logic [SW-1:0] slot_t;

  localparam slot_t HEAD  = SW'(sdll_pkg::HEAD_SLOT);
  localparam slot_t TAIL  = SW'(sdll_pkg::TAIL_SLOT);
  localparam slot_t FIRST = SW'(sdll_pkg::FIRST_SLOT);

  // insert number of a slot; both ends read as 0
  function automatic logic [NUM_W-1:0] slot_num(input slot_t s);
    slot_t d;
    d = s - SW'(1);
    if (s < FIRST) begin
      return '0;
    end
    return NUM_W'(d);
  endfunction

  // storage
  logic [VALUE_BITS-1:0] val_mem   [SLOTS];
  slot_t                 left_mem  [SLOTS];
  slot_t                 right_mem [SLOTS];
  logic                  dead_mem  [SLOTS];

  // incoming fields
  logic [FUNC_W-1:0] in_func;
  logic [NUM_W-1:0]  in_pos;
  logic [VAL_W-1:0]  in_value;
  slot_t             in_k;

  assign in_func  = s_tdata[FUNC_W-1:0];
  assign in_pos   = s_tdata[FUNC_W +: NUM_W];
  assign in_value = s_tdata[FUNC_W+NUM_W +: VAL_W];
  assign in_k     = SW'({1'b0, in_pos} + (NUM_W+1)'(1));

  // operation held over the sequence
  logic [FUNC_W-1:0] func;
  logic [NUM_W-1:0]  pos;
  logic [VAL_W-1:0]  value;

  // read data, addressed at acceptance
  logic [VALUE_BITS-1:0] rd_val;
  slot_t                 rd_left;
  slot_t                 rd_right;
  logic                  rd_dead;

  // list ends and allocator
  slot_t       head_right;
  slot_t       tail_left;
  logic [SW:0] next_free;

  // neighbours latched for the second write cycle
  slot_t la;
  slot_t lb;
  slot_t ls;

  // result register
  logic [STAT_W-1:0] res_status;
  logic [NUM_W-1:0]  res_num;
  logic [VAL_W-1:0]  res_val;
  logic [NUM_W-1:0]  res_left;
  logic [NUM_W-1:0]  res_right;

  // evaluation
  logic [NUM_W:0]    k_full;
  slot_t             k;
  slot_t             nf;
  logic              in_range;
  logic              live;
  logic              full;
  logic              is_ins;
  logic              needs_live;
  logic              ins_ok;
  logic              del_ok;
  slot_t             sel_a;
  slot_t             sel_b;
  logic [VMAX-1:0]   val_wide;
  logic [VALUE_BITS-1:0] val_store;
  logic [STAT_W-1:0] st_next;
  logic [NUM_W-1:0]  num_next;
  logic [VAL_W-1:0]  val_next;
  logic [NUM_W-1:0]  left_next;
  logic [NUM_W-1:0]  right_next;

  assign k_full     = {1'b0, pos} + (NUM_W+1)'(1);
  assign k          = SW'(k_full);
  assign nf         = next_free[SW-1:0];
  assign in_range   = int'(k_full) < SLOTS;
  assign live       = (pos != '0) && in_range && ({1'b0, k} < next_free) && !rd_dead;
  assign full       = int'(next_free) >= SLOTS;
  assign is_ins     = (func <= sdll_pkg::FN_INS_LEFT);
  assign needs_live = (func == sdll_pkg::FN_INS_RIGHT) || (func == sdll_pkg::FN_INS_LEFT)
                      || (func == sdll_pkg::FN_DELETE)
                      || ((func == sdll_pkg::FN_QUERY) && (pos != '0));
  assign ins_ok     = is_ins && (!needs_live || live) && !full;
  assign del_ok     = (func == sdll_pkg::FN_DELETE) && live;

  assign stat.need_link = ins_ok;

  // stored in the low bits; read back sign-extended
  assign val_wide  = VMAX'(value);
  assign val_store = val_wide[VALUE_BITS-1:0];
  assign val_next  = ((func == sdll_pkg::FN_QUERY) && (pos != '0) && live)
                     ? VAL_W'(signed'(rd_val)) : '0;

  // neighbours of the new node, or of the node being removed
  always_comb begin
    case (func)
      sdll_pkg::FN_PUSH_FRONT: begin
        sel_a = HEAD;
        sel_b = head_right;
      end
      sdll_pkg::FN_PUSH_BACK: begin
        sel_a = tail_left;
        sel_b = TAIL;
      end
      sdll_pkg::FN_INS_RIGHT: begin
        sel_a = k;
        sel_b = rd_right;
      end
      sdll_pkg::FN_INS_LEFT: begin
        sel_a = rd_left;
        sel_b = k;
      end
      default: begin
        sel_a = rd_left;
        sel_b = rd_right;
      end
    endcase
  end

  always_comb begin
    st_next    = sdll_pkg::ST_OK;
    num_next   = '0;
    left_next  = '0;
    right_next = '0;
    case (func)
      sdll_pkg::FN_QUERY: begin
        if (pos == '0) begin
          left_next  = slot_num(tail_left);
          right_next = slot_num(head_right);
        end else if (!live) begin
          st_next = sdll_pkg::ST_NOT_LIVE;
        end else begin
          num_next   = pos;
          left_next  = slot_num(rd_left);
          right_next = slot_num(rd_right);
        end
      end
      sdll_pkg::FN_DELETE: begin
        if (!live) begin
          st_next = sdll_pkg::ST_NOT_LIVE;
        end else begin
          num_next = pos;
        end
      end
      sdll_pkg::FN_PUSH_FRONT, sdll_pkg::FN_PUSH_BACK,
      sdll_pkg::FN_INS_RIGHT, sdll_pkg::FN_INS_LEFT: begin
        if (needs_live && !live) begin
          st_next = sdll_pkg::ST_NOT_LIVE;
        end else if (full) begin
          st_next = sdll_pkg::ST_FULL;
        end else begin
          num_next = slot_num(nf);
        end
      end
      default: begin
        st_next = sdll_pkg::ST_OK;
      end
    endcase
  end

  // write ports, one per memory per cycle
  logic  lw_en;
  slot_t lw_addr;
  slot_t lw_data;
  logic  rw_en;
  slot_t rw_addr;
  slot_t rw_data;
  logic  dw_en;
  slot_t dw_addr;
  logic  dw_data;

  always_comb begin
    lw_en   = 1'b0;
    lw_addr = nf;
    lw_data = sel_a;
    rw_en   = 1'b0;
    rw_addr = nf;
    rw_data = sel_b;
    dw_en   = 1'b0;
    dw_addr = nf;
    dw_data = 1'b0;
    if (cmd.eval && ins_ok) begin
      lw_en = 1'b1;
      rw_en = 1'b1;
      dw_en = 1'b1;
    end else if (cmd.eval && del_ok) begin
      lw_en   = (sel_b != TAIL);
      lw_addr = sel_b;
      lw_data = sel_a;
      rw_en   = (sel_a != HEAD);
      rw_addr = sel_a;
      rw_data = sel_b;
      dw_en   = 1'b1;
      dw_addr = k;
      dw_data = 1'b1;
    end else if (cmd.link) begin
      lw_en   = (lb != TAIL);
      lw_addr = lb;
      lw_data = ls;
      rw_en   = (la != HEAD);
      rw_addr = la;
      rw_data = ls;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && ins_ok) begin
      val_mem[nf] <= val_store;
    end
    if (cmd.accept) begin
      rd_val <= val_mem[in_k];
    end
  end

  always_ff @(posedge clk) begin
    if (lw_en) begin
      left_mem[lw_addr] <= lw_data;
    end
    if (cmd.accept) begin
      rd_left <= left_mem[in_k];
    end
  end

  always_ff @(posedge clk) begin
    if (rw_en) begin
      right_mem[rw_addr] <= rw_data;
    end
    if (cmd.accept) begin
      rd_right <= right_mem[in_k];
    end
  end

  always_ff @(posedge clk) begin
    if (dw_en) begin
      dead_mem[dw_addr] <= dw_data;
    end
    if (cmd.accept) begin
      rd_dead <= dead_mem[in_k];
    end
  end

  // operation, link payload, result and output registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func  <= in_func;
      pos   <= in_pos;
      value <= in_value;
    end
    if (cmd.eval) begin
      la         <= sel_a;
      lb         <= sel_b;
      ls         <= nf;
      res_status <= st_next;
      res_num    <= num_next;
      res_val    <= val_next;
      res_left   <= left_next;
      res_right  <= right_next;
    end
    if (cmd.load_out) begin
      m_tdata <= {res_right, res_left, res_val, res_num, res_status};
    end
  end

  // list ends and allocator
  always_ff @(posedge clk) begin
    if (rst) begin
      head_right <= TAIL;
      tail_left  <= HEAD;
      next_free  <= (SW+1)'(sdll_pkg::FIRST_SLOT);
    end else begin
      if (cmd.eval && del_ok) begin
        if (sel_a == HEAD) begin
          head_right <= sel_b;
        end
        if (sel_b == TAIL) begin
          tail_left <= sel_a;
        end
      end else if (cmd.link) begin
        if (la == HEAD) begin
          head_right <= ls;
        end
        if (lb == TAIL) begin
          tail_left <= ls;
        end
        next_free <= next_free + (SW+1)'(1);
      end
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import sdll_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RESET_CYC   = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_OPS  = 600;
  localparam int QUIET_CYC   = 12;
  localparam int MAX_REPORTS = 40;

  // func codes that the block leaves unused
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  // operation transfer, first field in the lowest bits
  typedef struct packed {
    logic [IN_W-FUNC_W-NUM_W-VAL_W-1:0] pad;
    logic [VAL_W-1:0]                   value;
    logic [NUM_W-1:0]                   pos;
    logic [FUNC_W-1:0]                  func;
  } op_t;

  // result transfer, first field in the lowest bits
  typedef struct packed {
    logic [NUM_W-1:0]  right_num;
    logic [NUM_W-1:0]  left_num;
    logic [VAL_W-1:0]  node_val;
    logic [NUM_W-1:0]  node_num;
    logic [STAT_W-1:0] status;
  } result_t;

  // Scoreboard: own copy of the linked list, plus the queue of answers due.
  class dll_scoreboard;
    logic [VAL_W-1:0] node_val [SLOTS_DEF];
    int               lnk_l    [SLOTS_DEF];
    int               lnk_r    [SLOTS_DEF];
    bit               live     [SLOTS_DEF];
    int               next_free;
    result_t          due_results [$];
    logic [NUM_W-1:0] live_nums [$];
    logic [NUM_W-1:0] dead_nums [$];
    int errors, checked, n_ins, n_del, n_query, n_spare, n_full, n_not_live;

    function new();
      foreach (live[i]) begin
        live[i]  = 1'b0;
        lnk_l[i] = 0;
        lnk_r[i] = 0;
      end
      lnk_r[HEAD_SLOT] = TAIL_SLOT;
      lnk_l[TAIL_SLOT] = HEAD_SLOT;
      next_free = FIRST_SLOT;
    endfunction

    // both ends read as 0
    function logic [NUM_W-1:0] num_of(int s);
      return (s < FIRST_SLOT) ? '0 : NUM_W'(s - 1);
    endfunction

    function bit is_live(logic [NUM_W-1:0] pos);
      int s;
      s = int'(pos) + 1;
      return pos != 0 && s < SLOTS_DEF && live[s];
    endfunction

    function bit pool_full();
      return next_free >= SLOTS_DEF;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function logic [NUM_W-1:0] pick_live();
      if (live_nums.size() == 0) return '0;
      return live_nums[$urandom_range(0, live_nums.size() - 1)];
    endfunction

    function logic [NUM_W-1:0] pick_dead();
      if (dead_nums.size() == 0) return NUM_W'($urandom_range(0, 1023));
      return dead_nums[$urandom_range(0, dead_nums.size() - 1)];
    endfunction

    // splice a new node in between slots a and b
    function int splice(int a, int b, logic [VAL_W-1:0] val);
      int s;
      s = next_free;
      node_val[s] = val;
      lnk_l[s] = a;
      lnk_r[s] = b;
      lnk_r[a] = s;
      lnk_l[b] = s;
      live[s]  = 1'b1;
      next_free = s + 1;
      live_nums.push_back(num_of(s));
      return s;
    endfunction

    function result_t predict_op(logic [FUNC_W-1:0] fn, logic [NUM_W-1:0] pos,
                                 logic [VAL_W-1:0] val);
      result_t r;
      int k, s;
      r = '0;
      k = int'(pos) + 1;
      if (fn == FN_SPARE_LO || fn == FN_SPARE_HI) return r;
      if (fn == FN_QUERY) begin
        if (pos == 0) begin
          r.left_num  = num_of(lnk_l[TAIL_SLOT]);
          r.right_num = num_of(lnk_r[HEAD_SLOT]);
        end else if (!is_live(pos)) begin
          r.status = ST_NOT_LIVE;
        end else begin
          r.node_num  = pos;
          r.node_val  = node_val[k];
          r.left_num  = num_of(lnk_l[k]);
          r.right_num = num_of(lnk_r[k]);
        end
        return r;
      end
      // liveness is checked ahead of the full check
      if (fn != FN_PUSH_FRONT && fn != FN_PUSH_BACK && !is_live(pos)) begin
        r.status = ST_NOT_LIVE;
        return r;
      end
      if (fn == FN_DELETE) begin
        lnk_r[lnk_l[k]] = lnk_r[k];
        lnk_l[lnk_r[k]] = lnk_l[k];
        live[k] = 1'b0;
        foreach (live_nums[i]) begin
          if (live_nums[i] == pos) begin
            live_nums.delete(i);
            break;
          end
        end
        dead_nums.push_back(pos);
        r.node_num = pos;
        return r;
      end
      if (pool_full()) begin
        r.status = ST_FULL;
        return r;
      end
      case (fn)
        FN_PUSH_FRONT: s = splice(HEAD_SLOT, lnk_r[HEAD_SLOT], val);
        FN_PUSH_BACK:  s = splice(lnk_l[TAIL_SLOT], TAIL_SLOT, val);
        FN_INS_RIGHT:  s = splice(k, lnk_r[k], val);
        default:       s = splice(lnk_l[k], k, val);
      endcase
      r.node_num = num_of(s);
      return r;
    endfunction

    function void note_op(logic [FUNC_W-1:0] fn, logic [NUM_W-1:0] pos,
                          logic [VAL_W-1:0] val);
      result_t r;
      r = predict_op(fn, pos, val);
      due_results.push_back(r);
      case (fn)
        FN_PUSH_FRONT, FN_PUSH_BACK, FN_INS_RIGHT, FN_INS_LEFT: n_ins++;
        FN_DELETE: n_del++;
        FN_QUERY:  n_query++;
        default:   n_spare++;
      endcase
      if (r.status == ST_FULL) n_full++;
      if (r.status == ST_NOT_LIVE) n_not_live++;
    endfunction

    task report(string msg);
      if (errors < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t exp;
      if (due_results.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", got));
        return;
      end
      exp = due_results.pop_front();
      checked++;
      if (got.status !== exp.status)
        report($sformatf("status %0d, want %0d", got.status, exp.status));
      if (got.node_num !== exp.node_num)
        report($sformatf("node_number %0d, want %0d", got.node_num, exp.node_num));
      if (got.node_val !== exp.node_val)
        report($sformatf("node_value %h, want %h", got.node_val, exp.node_val));
      if (got.left_num !== exp.left_num)
        report($sformatf("left_number %0d, want %0d", got.left_num, exp.left_num));
      if (got.right_num !== exp.right_num)
        report($sformatf("right_number %0d, want %0d", got.right_num, exp.right_num));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;

  int                   idle_pct  = 0;   // sender gap chance, per cent
  int                   stall_pct = 0;   // receiver stall chance, per cent
  int                   cycle_count = 0;
  dll_scoreboard        sb = new();

  static_doubly_linked_list i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Result side: check on each transfer, then decide the next cycle's tready.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(result_t'(m_tdata));
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: any hang ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One operation transfer. Gaps come before tvalid rises; tvalid is held
  // high straight into the next item when no gap is drawn.
  task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [NUM_W-1:0] pos,
                         input logic [VAL_W-1:0] val);
    op_t op;
    op = '{pad: '0, value: val, pos: pos, func: fn};
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= op;
    do @(posedge clk); while (!s_tready);
    sb.note_op(fn, pos, val);
  endtask

  // sender holds off until the block has answered everything
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Insert of the given kind; right and left inserts go next to a live node and
  // fall back to a push at the back on an empty list.
  task automatic send_insert(input logic [FUNC_W-1:0] fn);
    logic [NUM_W-1:0] ref_num;
    ref_num = sb.pick_live();
    if ((fn == FN_INS_RIGHT || fn == FN_INS_LEFT) && ref_num == 0) fn = FN_PUSH_BACK;
    send_op(fn, ref_num, $urandom);
  endtask

  function automatic logic [FUNC_W-1:0] FN_FUNC_RAND();
    return FUNC_W'($urandom_range(FN_INS_RIGHT, FN_QUERY));
  endfunction

  // Mostly well-formed traffic against live nodes, with some noise:
  // stale or unallocated positions, out-of-pool positions and spare codes.
  task automatic random_op();
    int               pick;
    logic [NUM_W-1:0] live_num;
    pick = $urandom_range(0, 99);
    live_num = sb.pick_live();
    if (pick < 14)      send_insert(FN_PUSH_FRONT);
    else if (pick < 28) send_insert(FN_PUSH_BACK);
    else if (pick < 44) send_insert(FN_INS_RIGHT);
    else if (pick < 60) send_insert(FN_INS_LEFT);
    else if (pick < 70) send_op(FN_DELETE, live_num, $urandom);
    else if (pick < 84) send_op(FN_QUERY, live_num, $urandom);
    else if (pick < 88) send_op(FN_QUERY, '0, $urandom);
    else if (pick < 93)
      send_op(FN_FUNC_RAND(), sb.pick_dead(), $urandom);
    else
      send_op(FUNC_W'($urandom_range(0, 7)), NUM_W'($urandom_range(0, 1023)), $urandom);
  endtask

  initial begin
    int                  phase;
    logic [FUNC_W-1:0]   kind;

    repeat (RESET_CYC) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list, dead and out-of-pool positions, value extremes,
    // both neighbours of a node, delete and reuse of a stale number, spare codes.
    send_op(FN_QUERY, '0, '0);
    send_op(FN_DELETE, '0, '0);
    send_op(FN_INS_RIGHT, '0, 32'h1234_5678);
    send_op(FN_INS_LEFT, 10'd1, 32'h0);
    send_op(FN_QUERY, 10'd1, '0);
    send_op(FN_QUERY, 10'h3FF, '0);
    send_op(FN_PUSH_FRONT, '0, 32'h7FFF_FFFF);
    send_op(FN_PUSH_BACK, 10'h3FF, 32'h8000_0000);
    send_op(FN_INS_RIGHT, 10'd1, 32'hFFFF_FFFF);
    send_op(FN_INS_LEFT, 10'd2, 32'h0);
    send_op(FN_QUERY, 10'd1, '0);
    send_op(FN_QUERY, 10'd2, '0);
    send_op(FN_QUERY, 10'd3, '0);
    send_op(FN_QUERY, 10'd4, '0);
    send_op(FN_QUERY, '0, 32'hFFFF_FFFF);
    send_op(FN_DELETE, 10'd2, '0);
    send_op(FN_QUERY, 10'd2, '0);
    send_op(FN_DELETE, 10'd2, '0);
    send_op(FN_INS_LEFT, 10'd2, 32'h5555_AAAA);
    send_op(FN_SPARE_LO, 10'h3FF, 32'hFFFF_FFFF);
    send_op(FN_SPARE_HI, 10'h2AA, 32'hAAAA_5555);
    send_op(FN_INS_RIGHT, 10'h3FF, 32'h1);
    send_op(FN_DELETE, 10'd1, '0);
    send_op(FN_QUERY, '0, '0);
    drain();

    // Random traffic in four phases of sender-gap and stall settings, sender paused between each.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      repeat (RANDOM_OPS / 4) random_op();
      drain();
    end

    // Fill the pool, with occasional queries and deletes along the way.
    idle_pct = 0;
    stall_pct = 0;
    while (!sb.pool_full()) begin
      case ($urandom_range(0, 19))
        0:       send_op(FN_QUERY, sb.pick_live(), $urandom);
        1:       send_op(FN_DELETE, sb.pick_live(), $urandom);
        default: send_insert(FUNC_W'($urandom_range(FN_PUSH_FRONT, FN_INS_LEFT)));
      endcase
    end

    // Pool exhausted: every insert kind is refused, a dead position still
    // reports not-live first, and deletes and queries keep working.
    idle_pct = 38;
    stall_pct = 38;
    for (kind = FN_PUSH_FRONT; kind <= FN_INS_LEFT; kind++) send_insert(kind);
    send_op(FN_INS_RIGHT, sb.pick_dead(), 32'hDEAD_BEEF);
    send_op(FN_INS_LEFT, 10'h3FF, 32'h0);
    send_op(FN_DELETE, sb.pick_live(), '0);
    send_op(FN_PUSH_BACK, '0, 32'h8000_0001);
    send_op(FN_QUERY, '0, '0);
    send_op(FN_QUERY, 10'h3FE, '0);
    repeat (40) random_op();

    drain();
    repeat (QUIET_CYC) @(posedge clk);

    $display("%0d operations: %0d inserts, %0d deletes, %0d queries, %0d spare codes",
             sb.n_ins + sb.n_del + sb.n_query + sb.n_spare, sb.n_ins, sb.n_del,
             sb.n_query, sb.n_spare);
    $display("%0d results checked (%0d pool-full, %0d not-live), %0d mismatches",
             sb.checked, sb.n_full, sb.n_not_live, sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
